FILE: src/kvss_pkg.sv
package kvss_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int KEY_W       = 31;
    localparam int PAY_W       = 64;

    typedef struct packed {
        logic insert;  // accepted word goes into the row
        logic drop;    // accepted word is lost, row full
        logic pop;     // head word taken by the receiver
    } kvss_cmd_t;

    typedef struct packed {
        logic full;
        logic one_left;
    } kvss_status_t;

endpackage

FILE: src/kvss_ctrl.sv
module kvss_ctrl
    import kvss_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    input  logic         last,
    input  logic         out_ready,
    input  kvss_status_t status,
    output logic         in_ready,
    output logic         out_valid,
    output kvss_cmd_t    cmd
);

    typedef enum logic {
        S_LOAD,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;
    logic   out_fire;

    assign in_ready  = (state_reg == S_LOAD);
    assign out_valid = (state_reg == S_EMIT);
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid && out_ready;

    assign cmd.insert = in_fire && !status.full;
    assign cmd.drop   = in_fire && status.full;
    assign cmd.pop    = out_fire;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_LOAD:
            begin
                if (in_fire && last)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                // back to loading once the final word is taken
                if (out_fire && status.one_left)
                begin
                    state_next = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

FILE: src/kvss_cells.sv
module kvss_cells
    import kvss_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  kvss_cmd_t          cmd,
    input  logic [KEY_W-1:0]   key,
    input  logic [PAY_W-1:0]   payload,
    output kvss_status_t       status,
    output logic [KEY_W-1:0]   sorted_key,
    output logic [PAY_W-1:0]   sorted_payload,
    output logic               end_of_list,
    output logic               overflow
);

    logic [KEY_W-1:0]   key_reg [MAX_ENTRIES];
    logic [PAY_W-1:0]   pay_reg [MAX_ENTRIES];
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               dropped_reg;
    logic               dropped_next;
    logic [MAX_ENTRIES-1:0] ins;

    // A cell moves aside when it is empty or holds a strictly larger key, so
    // equal keys stay ahead of the new word. The vector is monotone.
    always_comb
    begin
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            ins[i] = (CNT_W'(i) >= count_reg) || (key_reg[i] > key);
        end
    end

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            logic take_new;
            logic take_prev;
            logic take_next;

            if (g == 0)
            begin : g_head
                assign take_new  = ins[g];
                assign take_prev = 1'b0;
            end
            else
            begin : g_body
                assign take_new  = ins[g] && !ins[g-1];
                assign take_prev = ins[g] && ins[g-1];
            end

            if (g == MAX_ENTRIES - 1)
            begin : g_tail
                assign take_next = 1'b0;
            end
            else
            begin : g_mid
                assign take_next = 1'b1;
            end

            always_ff @(posedge clk)
            begin
                if (cmd.insert)
                begin
                    if (take_new)
                    begin
                        key_reg[g] <= key;
                        pay_reg[g] <= payload;
                    end
                    else if (take_prev)
                    begin
                        key_reg[g] <= key_reg[(g == 0) ? 0 : g - 1];
                        pay_reg[g] <= pay_reg[(g == 0) ? 0 : g - 1];
                    end
                end
                else if (cmd.pop && take_next)
                begin
                    // advance the row toward the head
                    key_reg[g] <= key_reg[(g == MAX_ENTRIES - 1) ? g : g + 1];
                    pay_reg[g] <= pay_reg[(g == MAX_ENTRIES - 1) ? g : g + 1];
                end
            end
        end
    endgenerate

    always_comb
    begin
        count_next   = count_reg;
        dropped_next = dropped_reg;
        if (cmd.insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end
        if (cmd.drop)
        begin
            dropped_next = 1'b1;
        end
        else if (cmd.pop && status.one_left)
        begin
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            count_reg   <= count_next;
            dropped_reg <= dropped_next;
        end
    end

    assign status.full     = (count_reg == CNT_W'(MAX_ENTRIES));
    assign status.one_left = (count_reg == CNT_W'(1));

    assign sorted_key     = key_reg[0];
    assign sorted_payload = pay_reg[0];
    assign end_of_list    = status.one_left;
    assign overflow       = dropped_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_ENTRIES))
        else $error("fill count beyond capacity");

    a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.pop && (cmd.insert || cmd.drop)))
        else $error("load and drain in the same cycle");

    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drop |-> status.full)
        else $error("word dropped while row not full");

    a_drain_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.pop && status.one_left) |=> (count_reg == '0) && !dropped_reg)
        else $error("list state not cleared after final word");

endmodule

FILE: src/key_value_stable_sort.sv
// Stable key/payload sorter.
// Input channel (in_valid/in_ready): one (key, payload) word per accepted
// cycle; last marks the final word of a list. Up to 64 words are kept per
// list; further words are dropped and every result of that list shows
// overflow.
// Output channel (out_valid/out_ready): the kept words in ascending key
// order, equal keys in arrival order, end_of_list on the final one.
// Loading places each word into a sorted row of registers as it arrives,
// all cells comparing in parallel. The first result is valid the cycle
// after last is accepted, then one word per cycle as the receiver takes
// them. in_ready is low while a list drains; a stalled receiver holds
// the head word and the whole row.
// Reset empties the row and clears the overflow flag; the block comes out
// of reset ready to load.
module key_value_stable_sort
    import kvss_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [KEY_W-1:0] key,
    input  logic [PAY_W-1:0] payload,
    input  logic             last,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [KEY_W-1:0] sorted_key,
    output logic [PAY_W-1:0] sorted_payload,
    output logic             end_of_list,
    output logic             overflow
);

    kvss_cmd_t    cmd;
    kvss_status_t status;

    kvss_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last      (last),
        .out_ready (out_ready),
        .status    (status),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    kvss_cells u_cells (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .key            (key),
        .payload        (payload),
        .status         (status),
        .sorted_key     (sorted_key),
        .sorted_payload (sorted_payload),
        .end_of_list    (end_of_list),
        .overflow       (overflow)
    );

endmodule
